FILE: src/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

  // Grid geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CELL_W  = 16;

  // Stream and config widths
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR   = 1'd1;

  // Command codes
  localparam logic [2:0] CMD_PUT_CURSOR = 3'd0;
  localparam logic [2:0] CMD_PUT_POS    = 3'd1;
  localparam logic [2:0] CMD_BACKSPACE  = 3'd2;
  localparam logic [2:0] CMD_CLEAR      = 3'd3;
  localparam logic [2:0] CMD_READ       = 3'd4;

  // Characters
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_BLANK   = 8'h08;
  localparam logic [7:0] CH_ERROR   = 8'h45;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_ERR_MARK,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_READ,
    OP_READ_ERR,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    K_NORMAL,
    K_NEWLINE,
    K_BLANK
  } kind_e;

  // Classified command as it travels through the queue
  typedef struct packed {
    op_e               op;
    logic              use_cursor;
    kind_e             kind;
    logic [7:0]        char_code;
    logic [7:0]        attr;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  // One result beat
  typedef struct packed {
    logic       scrolled;
    logic       coord_error;
    logic [7:0] cell_attr;
    logic [7:0] cell_char;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
  } res_t;

endpackage
`default_nettype wire

FILE: src/tcw_ram.sv
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: src/tcw_queue.sv
`default_nettype none
module tcw_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire tcw_pkg::entry_t push_entry_i,
  input  wire logic            pop_i,
  output tcw_pkg::entry_t      head_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import tcw_pkg::*;

  entry_t            ent_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = ent_q[rptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wptr_q] <= push_entry_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/tcw_front.sv
`default_nettype none
module tcw_front (
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [tcw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  wire logic [tcw_pkg::IN_USER_W-1:0]      s_axis_tuser,
  input  wire logic [7:0]                         def_attr_i,
  input  wire logic                               init_done_i,
  input  wire logic                               full_i,
  output logic                                    push_o,
  output tcw_pkg::entry_t                         entry_o
);
  import tcw_pkg::*;

  logic [7:0] char_code, attr;
  logic [6:0] col;
  logic [4:0] row;
  logic       in_grid;

  // unpack the beat
  assign char_code = s_axis_tdata[7:0];
  assign attr      = s_axis_tdata[15:8];
  assign col       = s_axis_tdata[22:16];
  assign row       = s_axis_tdata[27:23];

  assign in_grid = ({1'b0, col} < 8'(COLUMNS)) && ({1'b0, row} < 6'(ROWS));

  // no beats while the cell store is being cleared after reset
  assign s_axis_tready = init_done_i && !full_i;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  // classify the command
  always_comb begin
    entry_o            = '0;
    entry_o.char_code  = char_code;
    entry_o.attr       = (attr == 8'd0) ? def_attr_i : attr;
    entry_o.col        = col[COL_W-1:0];
    entry_o.row        = row[ROW_W-1:0];
    entry_o.addr       = ADDR_W'(row[ROW_W-1:0]) * ADDR_W'(COLUMNS)
                       + ADDR_W'(col[COL_W-1:0]);
    entry_o.use_cursor = 1'b0;

    priority if (char_code == CH_NEWLINE) begin
      entry_o.kind = K_NEWLINE;
    end else if (char_code == CH_BLANK) begin
      entry_o.kind = K_BLANK;
    end else begin
      entry_o.kind = K_NORMAL;
    end

    unique case (s_axis_tuser)
      CMD_PUT_CURSOR: begin
        entry_o.op         = OP_PUT;
        entry_o.use_cursor = 1'b1;
      end
      CMD_PUT_POS:   entry_o.op = in_grid ? OP_PUT : OP_ERR_MARK;
      CMD_BACKSPACE: entry_o.op = OP_BACKSPACE;
      CMD_CLEAR:     entry_o.op = OP_CLEAR;
      CMD_READ:      entry_o.op = in_grid ? OP_READ : OP_READ_ERR;
      default:       entry_o.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/tcw_back.sv
`default_nettype none
module tcw_back (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire tcw_pkg::entry_t                    head_i,
  input  wire logic                               empty_i,
  output logic                                    pop_o,
  input  wire logic [7:0]                         def_attr_i,
  input  wire logic [7:0]                         err_attr_i,
  output logic                                    init_done_o,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [tcw_pkg::OUT_DATA_W-1:0]          m_axis_tdata
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL,
    ST_CLEAR
  } state_e;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELLS - COLUMNS - 1);

  state_e            state_q;
  logic [ADDR_W-1:0] cnt_q;
  logic              wr_pend_q;
  logic [ADDR_W-1:0] wr_addr_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic              out_valid_q;
  res_t              out_q;

  logic [ADDR_W-1:0] cur_addr;
  logic              emit;
  res_t              res_d;

  // decode of the head command
  logic              dec_we, dec_emit, dec_err;
  logic [ADDR_W-1:0] dec_waddr;
  logic [CELL_W-1:0] dec_wdata;
  logic [COL_W-1:0]  dec_col;
  logic [ROW_W-1:0]  dec_row;
  state_e            dec_next;

  // RAM port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  assign cur_addr    = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
  assign init_done_o = (state_q != ST_INIT);
  // a new command starts only when the result slot is free or draining
  assign pop_o       = (state_q == ST_IDLE) && !empty_i
                    && (!out_valid_q || m_axis_tready);

  // execute one command: cell write, cursor motion, next state
  always_comb begin
    logic [COL_W-1:0]  tcol;
    logic [ROW_W-1:0]  trow;
    logic [ADDR_W-1:0] taddr;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic              wrap;

    tcol    = head_i.use_cursor ? col_q : head_i.col;
    trow    = head_i.use_cursor ? row_q : head_i.row;
    taddr   = head_i.use_cursor ? cur_addr : head_i.addr;
    col_inc = {1'b0, tcol} + 1'b1;
    row_inc = {1'b0, trow} + 1'b1;
    wrap    = 1'b0;

    dec_we    = 1'b0;
    dec_waddr = taddr;
    dec_wdata = {head_i.attr, head_i.char_code};
    dec_col   = col_q;
    dec_row   = row_q;
    dec_err   = 1'b0;
    dec_emit  = 1'b1;
    dec_next  = ST_IDLE;

    unique case (head_i.op)
      OP_PUT: begin
        dec_col = tcol;
        dec_row = trow;
        unique case (head_i.kind)
          K_NEWLINE: wrap = 1'b1;
          K_BLANK: begin
            dec_we    = 1'b1;
            dec_wdata = {head_i.attr, CH_SPACE};
          end
          default: begin
            dec_we = 1'b1;
            if (col_inc == (COL_W+1)'(COLUMNS)) begin
              wrap = 1'b1;
            end else begin
              dec_col = col_inc[COL_W-1:0];
            end
          end
        endcase
        // start of next row, scrolling past the bottom
        if (wrap) begin
          dec_col = '0;
          if (row_inc == (ROW_W+1)'(ROWS)) begin
            dec_row  = ROW_W'(ROWS - 1);
            dec_emit = 1'b0;
            dec_next = ST_COPY;
          end else begin
            dec_row = row_inc[ROW_W-1:0];
          end
        end
      end
      OP_ERR_MARK: begin
        dec_we    = 1'b1;
        dec_waddr = LAST_CELL;
        dec_wdata = {err_attr_i, CH_ERROR};
        dec_err   = 1'b1;
      end
      OP_BACKSPACE: begin
        if (col_q != '0) begin
          dec_col = col_q - 1'b1;
        end else if (row_q != '0) begin
          dec_col = COL_W'(COLUMNS - 1);
          dec_row = row_q - 1'b1;
        end
        dec_we    = 1'b1;
        dec_waddr = (cur_addr == '0) ? '0 : cur_addr - 1'b1;
        dec_wdata = {def_attr_i, CH_SPACE};
      end
      OP_CLEAR: begin
        dec_col  = '0;
        dec_row  = '0;
        dec_emit = 1'b0;
        dec_next = ST_CLEAR;
      end
      OP_READ: begin
        dec_emit = 1'b0;
        dec_next = ST_READ;
      end
      OP_READ_ERR: dec_err = 1'b1;
      default: ;
    endcase
  end

  // RAM write mux and read address
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = '0;
    ram_raddr = head_i.addr;
    unique case (state_q)
      ST_INIT: ram_we = 1'b1;
      ST_IDLE: begin
        ram_we    = pop_o && dec_we;
        ram_waddr = dec_waddr;
        ram_wdata = dec_wdata;
      end
      ST_COPY: begin
        ram_raddr = cnt_q + ADDR_W'(COLUMNS);
        ram_we    = wr_pend_q;
        ram_waddr = wr_addr_q;
        ram_wdata = ram_rdata;
      end
      ST_FILL: begin
        // the last copied cell goes first, then the zero row
        ram_we = 1'b1;
        if (wr_pend_q) begin
          ram_waddr = wr_addr_q;
          ram_wdata = ram_rdata;
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = {def_attr_i, CH_SPACE};
      end
      default: ;
    endcase
  end

  // result beat
  always_comb begin
    res_d            = '0;
    res_d.cursor_col = 7'(col_q);
    res_d.cursor_row = 5'(row_q);
    emit             = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        emit              = pop_o && dec_emit;
        res_d.cursor_col  = 7'(dec_col);
        res_d.cursor_row  = 5'(dec_row);
        res_d.coord_error = dec_err;
      end
      ST_READ: begin
        emit            = 1'b1;
        res_d.cell_char = ram_rdata[7:0];
        res_d.cell_attr = ram_rdata[15:8];
      end
      ST_FILL: begin
        emit           = !wr_pend_q && (cnt_q == LAST_CELL);
        res_d.scrolled = 1'b1;
      end
      ST_CLEAR: emit = (cnt_q == LAST_CELL);
      default: ;
    endcase
  end

  // sequencer state, cursor and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      wr_pend_q   <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_INIT: begin
          if (cnt_q == LAST_CELL) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (pop_o) begin
            col_q   <= dec_col;
            row_q   <= dec_row;
            cnt_q   <= '0;
            state_q <= dec_next;
          end
        end
        ST_READ: state_q <= ST_IDLE;
        ST_COPY: begin
          wr_pend_q <= 1'b1;
          cnt_q     <= cnt_q + 1'b1;
          if (cnt_q == COPY_LAST) begin
            state_q <= ST_FILL;
          end
        end
        ST_FILL: begin
          if (wr_pend_q) begin
            wr_pend_q <= 1'b0;
          end else if (cnt_q == LAST_CELL) begin
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_CLEAR: begin
          if (cnt_q == LAST_CELL) begin
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res_d;
    end
    wr_addr_q <= cnt_q;
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - $bits(res_t))'(0), out_q};

endmodule
`default_nettype wire

FILE: src/text_console_writer_unit.sv
// A beat is queued, run from the queue head and its result registered (a read via ST_READ).
// Throughput: up to one command per cycle while results are taken; a scroll holds the
//   back end for its row copy and fill, a clear for its sweep (single RAM write port).
// Reset: asynchronous, active low; afterwards the CELLS cells (2000 at 80x25) of the cell
//   store are swept to zero with s_axis_tready low; config writes are taken throughout.
`default_nettype none
module text_console_writer_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // tdata: char_code[7:0], attribute[15:8], col[22:16], row[27:23], zero[31:28]
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [tcw_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // tuser: command[2:0]
  input  wire logic [tcw_pkg::IN_USER_W-1:0]       s_axis_tuser,
  // tdata: cursor_col[6:0], cursor_row[11:7], cell_char[19:12], cell_attr[27:20],
  //        coord_error[28], scrolled[29], zero[31:30]
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [tcw_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
  input  wire logic                                cfg_we_i,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import tcw_pkg::*;

  logic [7:0] def_attr_q, err_attr_q;
  logic       init_done, q_full, q_empty, push, pop;
  entry_t     push_entry, head;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_attr_q <= 8'd15;
      err_attr_q <= 8'd244;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEFAULT_ATTR: def_attr_q <= cfg_data_i;
        CFG_ERROR_ATTR:   err_attr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcw_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .def_attr_i    (def_attr_q),
    .init_done_i   (init_done),
    .full_i        (q_full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  tcw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  tcw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .def_attr_i    (def_attr_q),
    .err_attr_i    (err_attr_q),
    .init_done_o   (init_done),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire

FILE: src/tcw_checker.sv
`default_nettype none
module tcw_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [tcw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import tcw_pkg::*;

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // cursor column stays on the grid
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, m_axis_tdata[6:0]} < 8'(COLUMNS)))
    else $error("cursor column off the grid");

  // cursor row stays on the grid
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, m_axis_tdata[11:7]} < 6'(ROWS)))
    else $error("cursor row off the grid");

  // a scroll comes only from a put: no read data, no error
  a_scroll_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[29] |->
      !m_axis_tdata[28] && (m_axis_tdata[27:12] == 16'd0))
    else $error("scroll beat carries read data or error");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (.*);
`default_nettype wire
